FILE: hw/rtl/elmc_pkg.sv
`timescale 1ns / 1ps

package elmc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int DATA_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CUTOFF_W    = 12;
    localparam int ACCEL_W     = 8;
    localparam int PROD_W      = 2 * DATA_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_MENU_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF_LEVEL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_MAX      = 2'd2;

    localparam logic [DATA_W-1:0]   MENU_PERIOD_RESET  = 16'd5000;
    localparam logic [CUTOFF_W-1:0] CUTOFF_LEVEL_RESET = 12'd280;
    localparam logic [DATA_W-1:0]   PWM_MAX_RESET      = 16'd1000;

    localparam logic [ACCEL_W-1:0] ACCEL_START   = 8'd125;
    localparam logic [ACCEL_W-1:0] ACCEL_FAST_UP = 8'd150;
    localparam logic [ACCEL_W-1:0] ACCEL_MAX     = 8'd175;
    localparam logic [ACCEL_W-1:0] ACCEL_FAST_DN = 8'd75;
    localparam logic [ACCEL_W-1:0] ACCEL_MIN     = 8'd50;
    localparam logic [DATA_W-1:0]  STEP_FLOOR    = 16'd51;
    localparam logic [DATA_W-1:0]  STEP_EXTRA    = 16'd50;

    // Capacity divides by 3600 = 16 * 225: a shift, then a reciprocal multiply by 1/225.
    localparam int CAP_DIV     = 3600;
    localparam int CAP_SHIFT   = 4;
    localparam int CAP_ODD     = CAP_DIV >> CAP_SHIFT;
    localparam int CAP_X_W     = PROD_W - CAP_SHIFT;
    localparam int CAP_FRAC    = CAP_X_W + 8;
    localparam int CAP_RECIP_W = 29;
    localparam int CAP_QFULL_W = CAP_X_W + CAP_RECIP_W;
    localparam logic [CAP_RECIP_W-1:0] CAP_RECIP =
        CAP_RECIP_W'(((64'd1 << CAP_FRAC) + 64'(CAP_ODD) - 64'd1) / 64'(CAP_ODD));

    typedef enum logic [3:0] {
        MODE_CHOOSE        = 4'd0,
        MODE_EDIT_POWER    = 4'd1,
        MODE_ARM_POWER     = 4'd2,
        MODE_POWER_REG     = 4'd3,
        MODE_EDIT_CURRENT  = 4'd4,
        MODE_ARM_BATTERY   = 4'd5,
        MODE_START_CURRENT = 4'd6,
        MODE_BATTERY_TEST  = 4'd7,
        MODE_BATTERY_DONE  = 4'd8,
        MODE_CURRENT_REG   = 4'd9
    } mode_t;

    typedef struct packed {
        logic [DATA_W-1:0]      pwm_compare;
        logic                   pwm_enable;
        logic [3:0]             menu_state;
        logic [DATA_W-1:0]      current_setpoint;
        logic [DATA_W-1:0]      power_setpoint;
        logic [DATA_W-1:0]      elapsed_count;
        logic [SAMPLE_BITS-1:0] dac_value;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [ACCEL_W-1:0] accel;
    } edit_t;

    function automatic edit_t edit_value(input logic [DATA_W-1:0] value,
                                         input logic [ACCEL_W-1:0] accel,
                                         input logic plus, input logic minus);
        edit_t r;
        r.value = value;
        r.accel = accel;
        if (plus)
        begin
            r.value = r.value + 16'd1;
            if (r.accel > ACCEL_FAST_UP && r.value > STEP_FLOOR)
            begin
                r.value = r.value + STEP_EXTRA;
            end
            if (r.accel >= ACCEL_MAX)
            begin
                r.accel = ACCEL_MAX;
            end
            else
            begin
                r.accel = r.accel + 8'd1;
            end
        end
        if (minus)
        begin
            r.value = r.value - 16'd1;
            if (r.accel < ACCEL_FAST_DN && r.value > STEP_FLOOR)
            begin
                r.value = r.value - STEP_EXTRA;
            end
            if (r.accel <= ACCEL_MIN)
            begin
                r.accel = ACCEL_MIN;
            end
            else
            begin
                r.accel = r.accel - 8'd1;
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/electronic_load_mode_controller_unit.sv
`timescale 1ns / 1ps

// Pipeline: three register stages, s1, s2 and the output register; an accepted item
// passes through them in that order before its result can transfer.
// Throughput: one item per cycle; the capacity divide runs as a two-stage multiply pipeline.
// All stages advance together and hold while the result register waits for a transfer.
// Reset (rst_n low, asynchronous) sets mode 6, acceleration 125, clears setpoints, PWM,
// latched samples, time count and capacity, and loads the register defaults.
module electronic_load_mode_controller_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [elmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [elmc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                start_button,
    input  logic                                plus_button,
    input  logic                                minus_button,
    input  logic                                sample_tick,
    input  logic [elmc_pkg::SAMPLE_BITS-1:0]    power_sample,
    input  logic [elmc_pkg::SAMPLE_BITS-1:0]    current_sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [elmc_pkg::DATA_W-1:0]         pwm_compare,
    output logic                                pwm_enable,
    output logic [3:0]                          menu_state,
    output logic [elmc_pkg::DATA_W-1:0]         current_setpoint,
    output logic [elmc_pkg::DATA_W-1:0]         power_setpoint,
    output logic [elmc_pkg::DATA_W-1:0]         capacity,
    output logic [elmc_pkg::DATA_W-1:0]         elapsed_count,
    output logic [elmc_pkg::SAMPLE_BITS-1:0]    dac_value
);

    logic [elmc_pkg::DATA_W-1:0]      menu_period_reg;
    logic [elmc_pkg::CUTOFF_W-1:0]    cutoff_level_reg;
    logic [elmc_pkg::DATA_W-1:0]      pwm_max_reg;

    elmc_pkg::mode_t                  mode_reg;
    elmc_pkg::mode_t                  mode_next;
    logic [elmc_pkg::DATA_W-1:0]      divider_reg;
    logic [elmc_pkg::DATA_W-1:0]      divider_next;
    logic [elmc_pkg::ACCEL_W-1:0]     accel_reg;
    logic [elmc_pkg::ACCEL_W-1:0]     accel_next;
    logic [elmc_pkg::DATA_W-1:0]      current_target_reg;
    logic [elmc_pkg::DATA_W-1:0]      current_target_next;
    logic [elmc_pkg::DATA_W-1:0]      power_target_reg;
    logic [elmc_pkg::DATA_W-1:0]      power_target_next;
    logic [elmc_pkg::DATA_W-1:0]      pwm_level_reg;
    logic [elmc_pkg::DATA_W-1:0]      pwm_level_next;
    logic                             pwm_running_reg;
    logic                             pwm_running_next;
    logic [elmc_pkg::SAMPLE_BITS-1:0] latched_power_reg;
    logic [elmc_pkg::SAMPLE_BITS-1:0] latched_power_next;
    logic [elmc_pkg::SAMPLE_BITS-1:0] latched_current_reg;
    logic [elmc_pkg::SAMPLE_BITS-1:0] latched_current_next;
    logic [elmc_pkg::DATA_W-1:0]      time_count_reg;
    logic [elmc_pkg::DATA_W-1:0]      time_count_next;
    logic                             cap_load;

    logic                             advance;
    logic                             accept;
    elmc_pkg::edit_t                  edit;
    logic                             regulate;
    logic [elmc_pkg::DATA_W-1:0]      measured;
    logic [elmc_pkg::DATA_W-1:0]      target;
    elmc_pkg::result_t                res_now;

    logic                             s1_valid_reg;
    elmc_pkg::result_t                s1_res_reg;
    logic [elmc_pkg::PROD_W-1:0]      s1_prod_reg;
    logic                             s1_load_reg;
    logic                             s2_valid_reg;
    elmc_pkg::result_t                s2_res_reg;
    logic [elmc_pkg::CAP_QFULL_W-1:0] s2_quot_reg;
    logic                             s2_load_reg;
    logic                             out_valid_reg;
    elmc_pkg::result_t                out_res_reg;
    logic [elmc_pkg::DATA_W-1:0]      capacity_reg;

    assign advance    = !out_valid_reg || result_ready;
    assign item_ready = advance;
    assign accept     = item_valid && advance;

    always_comb
    begin
        edit                 = '0;
        mode_next            = mode_reg;
        accel_next           = accel_reg;
        current_target_next  = current_target_reg;
        power_target_next    = power_target_reg;
        pwm_running_next     = pwm_running_reg;
        time_count_next      = time_count_reg;
        cap_load             = 1'b0;
        divider_next         = divider_reg + 16'd1;

        if (divider_reg > menu_period_reg)
        begin
            divider_next = 16'd1;
            case (mode_reg)
                elmc_pkg::MODE_CHOOSE:
                begin
                    accel_next = elmc_pkg::ACCEL_START;
                    if (plus_button)
                    begin
                        mode_next = elmc_pkg::MODE_EDIT_POWER;
                    end
                    if (minus_button)
                    begin
                        mode_next = elmc_pkg::MODE_EDIT_CURRENT;
                    end
                end
                elmc_pkg::MODE_EDIT_POWER:
                begin
                    edit = elmc_pkg::edit_value(power_target_reg, accel_reg,
                                                plus_button, minus_button);
                    power_target_next = edit.value;
                    accel_next        = edit.accel;
                    if (start_button)
                    begin
                        mode_next = elmc_pkg::MODE_ARM_POWER;
                    end
                end
                elmc_pkg::MODE_ARM_POWER:
                begin
                    if (plus_button)
                    begin
                        pwm_running_next = 1'b1;
                        mode_next        = elmc_pkg::MODE_POWER_REG;
                    end
                    if (minus_button)
                    begin
                        mode_next = elmc_pkg::MODE_START_CURRENT;
                    end
                end
                elmc_pkg::MODE_POWER_REG:
                begin
                    if (start_button)
                    begin
                        pwm_running_next = 1'b0;
                        mode_next        = elmc_pkg::MODE_START_CURRENT;
                    end
                end
                elmc_pkg::MODE_EDIT_CURRENT:
                begin
                    edit = elmc_pkg::edit_value(current_target_reg, accel_reg,
                                                plus_button, minus_button);
                    current_target_next = edit.value;
                    accel_next          = edit.accel;
                    if (start_button)
                    begin
                        mode_next = elmc_pkg::MODE_ARM_BATTERY;
                    end
                end
                elmc_pkg::MODE_ARM_BATTERY:
                begin
                    if (plus_button)
                    begin
                        pwm_running_next = 1'b1;
                        time_count_next  = '0;
                        mode_next        = elmc_pkg::MODE_BATTERY_TEST;
                    end
                    if (minus_button)
                    begin
                        mode_next = elmc_pkg::MODE_START_CURRENT;
                    end
                end
                elmc_pkg::MODE_START_CURRENT:
                begin
                    pwm_running_next = 1'b1;
                    mode_next        = elmc_pkg::MODE_CURRENT_REG;
                end
                elmc_pkg::MODE_BATTERY_TEST:
                begin
                    if (latched_power_reg < cutoff_level_reg)
                    begin
                        pwm_running_next = 1'b0;
                        cap_load         = 1'b1;
                        mode_next        = elmc_pkg::MODE_BATTERY_DONE;
                    end
                    if (start_button && !plus_button)
                    begin
                        pwm_running_next = 1'b0;
                        mode_next        = elmc_pkg::MODE_START_CURRENT;
                    end
                end
                elmc_pkg::MODE_BATTERY_DONE:
                begin
                    if (start_button)
                    begin
                        mode_next = elmc_pkg::MODE_START_CURRENT;
                    end
                end
                elmc_pkg::MODE_CURRENT_REG:
                begin
                    if (start_button)
                    begin
                        pwm_running_next = 1'b0;
                        mode_next        = elmc_pkg::MODE_CHOOSE;
                    end
                    edit = elmc_pkg::edit_value(current_target_reg, accel_reg,
                                                plus_button, minus_button);
                    current_target_next = edit.value;
                    accel_next          = edit.accel;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        regulate = 1'b0;
        measured = elmc_pkg::DATA_W'(latched_current_reg);
        target   = current_target_next;
        if (mode_next == elmc_pkg::MODE_POWER_REG)
        begin
            regulate = 1'b1;
            measured = elmc_pkg::DATA_W'(latched_power_reg);
            target   = power_target_next;
        end
        else if (mode_next == elmc_pkg::MODE_CURRENT_REG
                 || mode_next == elmc_pkg::MODE_BATTERY_TEST)
        begin
            regulate = 1'b1;
        end

        pwm_level_next = pwm_level_reg;
        if (regulate)
        begin
            if (measured > target && pwm_level_reg > 16'd1)
            begin
                pwm_level_next = pwm_level_reg - 16'd1;
            end
            else if (measured < target && pwm_level_reg < pwm_max_reg)
            begin
                pwm_level_next = pwm_level_reg + 16'd1;
            end
        end

        latched_power_next   = latched_power_reg;
        latched_current_next = latched_current_reg;
        if (sample_tick)
        begin
            latched_power_next   = power_sample;
            latched_current_next = current_sample;
            time_count_next      = time_count_next + 16'd1;
        end

        res_now.pwm_compare      = pwm_level_next;
        res_now.pwm_enable       = pwm_running_next;
        res_now.menu_state       = mode_next;
        res_now.current_setpoint = current_target_next;
        res_now.power_setpoint   = power_target_next;
        res_now.elapsed_count    = time_count_next;
        res_now.dac_value        = latched_current_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            menu_period_reg  <= elmc_pkg::MENU_PERIOD_RESET;
            cutoff_level_reg <= elmc_pkg::CUTOFF_LEVEL_RESET;
            pwm_max_reg      <= elmc_pkg::PWM_MAX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                elmc_pkg::CFG_MENU_PERIOD:  menu_period_reg  <= cfg_data;
                elmc_pkg::CFG_CUTOFF_LEVEL: cutoff_level_reg <= cfg_data[elmc_pkg::CUTOFF_W-1:0];
                elmc_pkg::CFG_PWM_MAX:      pwm_max_reg      <= cfg_data;
                default:                    menu_period_reg  <= menu_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= elmc_pkg::MODE_START_CURRENT;
            divider_reg         <= '0;
            accel_reg           <= elmc_pkg::ACCEL_START;
            current_target_reg  <= '0;
            power_target_reg    <= '0;
            pwm_level_reg       <= '0;
            pwm_running_reg     <= 1'b0;
            latched_power_reg   <= '0;
            latched_current_reg <= '0;
            time_count_reg      <= '0;
        end
        else if (accept)
        begin
            mode_reg            <= mode_next;
            divider_reg         <= divider_next;
            accel_reg           <= accel_next;
            current_target_reg  <= current_target_next;
            power_target_reg    <= power_target_next;
            pwm_level_reg       <= pwm_level_next;
            pwm_running_reg     <= pwm_running_next;
            latched_power_reg   <= latched_power_next;
            latched_current_reg <= latched_current_next;
            time_count_reg      <= time_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg && s2_load_reg)
            begin
                capacity_reg <= s2_quot_reg[elmc_pkg::CAP_FRAC +: elmc_pkg::DATA_W];
            end
        end
    end

    // The product uses the target and time count as they stood before this transfer.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_res_reg  <= res_now;
            s1_prod_reg <= elmc_pkg::PROD_W'(current_target_reg)
                           * elmc_pkg::PROD_W'(time_count_reg);
            s1_load_reg <= accept && cap_load;
            s2_res_reg  <= s1_res_reg;
            s2_quot_reg <= elmc_pkg::CAP_QFULL_W'(s1_prod_reg[elmc_pkg::PROD_W-1:elmc_pkg::CAP_SHIFT])
                           * elmc_pkg::CAP_QFULL_W'(elmc_pkg::CAP_RECIP);
            s2_load_reg <= s1_valid_reg && s1_load_reg;
            out_res_reg <= s2_res_reg;
        end
    end

    assign result_valid     = out_valid_reg;
    assign pwm_compare      = out_res_reg.pwm_compare;
    assign pwm_enable       = out_res_reg.pwm_enable;
    assign menu_state       = out_res_reg.menu_state;
    assign current_setpoint = out_res_reg.current_setpoint;
    assign power_setpoint   = out_res_reg.power_setpoint;
    assign capacity         = capacity_reg;
    assign elapsed_count    = out_res_reg.elapsed_count;
    assign dac_value        = out_res_reg.dac_value;

endmodule
